FILE: rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared widths for the modular exponentiation block and its checker.
// ----------------------------------------------------------------------------
package modexp_pkg;

	// width of base_value, exponent, modulus register and power_result
	localparam int DATA_W = 32;
	// input beat carries base_value and exponent
	localparam int IN_W = 2 * DATA_W;
	// counter over the bits of one serial pass
	localparam int CNT_W = $clog2(DATA_W);

endpackage

FILE: rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Left-to-right binary square-and-multiply, base^exponent mod modulus.
// ----------------------------------------------------------------------------
// The block handles one item at a time. An accepted beat first reduces the
// base modulo the modulus, one base bit per cycle. It then walks all EXP_BITS
// exponent bits from the top: a squaring, and a multiply by the base where the
// bit is set. Each modular multiplication runs in one shared bit-serial unit
// (shift-and-add with one conditional subtract per doubling and per add). An
// exponent of zero returns 1. The finished result waits in an output register,
// so the next item is taken while it is still unread. A modulus register value
// of zero acts as 2^MOD_BITS. The user must write the modulus only while the
// block idles; the block itself does not enforce it.
module modular_exponentiation
	import modexp_pkg::*;
#(
	parameter int MOD_BITS = 32,
	parameter int EXP_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [DATA_W-1:0] cfg_data,        // modulus
	// input stream
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_W-1:0]   s_axis_tdata,    // [31:0] base_value, [63:32] exponent
	// result stream
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata     // [31:0] power_result
);

	localparam int ECW = $clog2(EXP_BITS + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_REDUCE = 3'd1;
	localparam logic [2:0] ST_SQR    = 3'd2;
	localparam logic [2:0] ST_MUL    = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]          state_q;
	logic [MOD_BITS-1:0] modulus_q;
	logic [MOD_BITS-1:0] r_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] base_q;
	logic [DATA_W-1:0]   bsh_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [ECW-1:0]      ecnt_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_data_q;

	logic [MOD_BITS:0]   m_ext;
	logic [MOD_BITS:0]   dbl;
	logic [MOD_BITS:0]   dbl_red;
	logic [MOD_BITS:0]   addend;
	logic [MOD_BITS:0]   sum;
	logic [MOD_BITS:0]   sum_red;
	logic [MOD_BITS-1:0] step_val;
	logic [MOD_BITS-1:0] a_sel;
	logic                bit_in;
	logic                in_beat;
	logic                out_beat;
	logic                pass_done;
	logic [IN_W-1:0]     exp_ext;
	logic [EXP_BITS-1:0] exp_in;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = out_valid_q && m_axis_tready;

	// exponent keeps only its low EXP_BITS bits, zero extended above 32
	assign exp_ext = IN_W'(s_axis_tdata[IN_W-1:DATA_W]);
	assign exp_in  = exp_ext[EXP_BITS-1:0];

	// effective modulus, zero register value means 2^MOD_BITS
	assign m_ext = (modulus_q == '0) ? {1'b1, {MOD_BITS{1'b0}}} : {1'b0, modulus_q};

	// one serial step: r = 2r mod m, then r = r + addend mod m
	always_comb begin
		a_sel   = (state_q == ST_MUL) ? base_q : acc_q;
		bit_in  = (state_q == ST_REDUCE) ? bsh_q[DATA_W-1] : bsh_q[MOD_BITS-1];
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
		if (state_q == ST_REDUCE) begin
			addend = (MOD_BITS+1)'(bit_in);
		end else begin
			addend = bit_in ? {1'b0, a_sel} : '0;
		end
		sum      = dbl_red + addend;
		sum_red  = (sum >= m_ext) ? (sum - m_ext) : sum;
		step_val = sum_red[MOD_BITS-1:0];
	end

	assign pass_done = (state_q == ST_REDUCE) ? (cnt_q == CNT_W'(DATA_W - 1))
	                                          : (cnt_q == CNT_W'(MOD_BITS - 1));

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			modulus_q <= cfg_data[MOD_BITS-1:0];
		end
	end

	// sequencer: base reduction, then square and multiply per exponent bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= (exp_in == '0) ? ST_FINISH : ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (pass_done) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (pass_done) begin
						if (exp_q[EXP_BITS-1]) begin
							state_q <= ST_MUL;
						end else if (ecnt_q == '0) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SQR;
						end
					end
				end
				ST_MUL: begin
					if (pass_done) begin
						state_q <= (ecnt_q == '0) ? ST_FINISH : ST_SQR;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers of the serial unit
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					bsh_q  <= s_axis_tdata[DATA_W-1:0];
					exp_q  <= exp_in;
					ecnt_q <= ECW'(EXP_BITS - 1);
					acc_q  <= MOD_BITS'(1);
					r_q    <= '0;
					cnt_q  <= '0;
				end
			end
			ST_REDUCE: begin
				if (pass_done) begin
					base_q <= step_val;
					r_q    <= '0;
					cnt_q  <= '0;
					bsh_q  <= DATA_W'(acc_q);
				end else begin
					r_q   <= step_val;
					cnt_q <= cnt_q + 1'b1;
					bsh_q <= bsh_q << 1;
				end
			end
			ST_SQR, ST_MUL: begin
				if (pass_done) begin
					acc_q <= step_val;
					r_q   <= '0;
					cnt_q <= '0;
					bsh_q <= DATA_W'(step_val);
					// move to the next exponent bit unless a multiply follows
					if (state_q == ST_MUL || !exp_q[EXP_BITS-1]) begin
						exp_q <= exp_q << 1;
						if (ecnt_q != '0) begin
							ecnt_q <= ecnt_q - 1'b1;
						end
					end
				end else begin
					r_q   <= step_val;
					cnt_q <= cnt_q + 1'b1;
					bsh_q <= bsh_q << 1;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && (!out_valid_q || m_axis_tready)) begin
			out_valid_q <= 1'b1;
		end else if (out_beat) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= DATA_W'(acc_q);
		end
	end

endmodule

FILE: rtl/modexp_chk.sv
// ----------------------------------------------------------------------------
// modexp_chk
// Port-level checks for the modular exponentiation block.
// ----------------------------------------------------------------------------
module modexp_chk
	import modexp_pkg::*;
#(
	parameter int MOD_BITS = 32
) (
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [DATA_W-1:0] m_axis_tdata
);

	// a stalled result beat stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its data
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result data changed while stalled");

	// one item at a time: no input beat right after one is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in progress");

	// a result is always below 2^MOD_BITS
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata >> MOD_BITS) == '0))
		else $error("result wider than the modulus");

	// the modulus only changes while no item is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> s_axis_tready)
		else $error("modulus written while an item is in progress");

endmodule

bind modular_exponentiation modexp_chk #(.MOD_BITS(MOD_BITS)) u_modexp_chk (.*);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for modular_exponentiation: a directed table of edge
// cases, then random base/exponent beats over a range of modulus settings,
// with random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
	import modexp_pkg::*;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// one directed row; power is only used where known is set
	typedef struct packed {
		bit [DATA_W-1:0] modulus;
		bit [DATA_W-1:0] base;
		bit [DATA_W-1:0] exponent;
		bit              known;
		bit [DATA_W-1:0] power;
	} stim_row_t;

	// one expected result with the inputs that produced it
	typedef struct packed {
		bit [DATA_W-1:0] base;
		bit [DATA_W-1:0] exponent;
		bit [DATA_W-1:0] power;
	} power_item_t;

	localparam int DIRECTED_ROWS = 22;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_ITEMS = 30;
	// worst case item, a squaring and a multiply on every exponent bit
	localparam int ITEM_CYCLES = 2100;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [DATA_W-1:0] cfg_data;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;    // [31:0] base_value, [63:32] exponent
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [DATA_W-1:0] m_axis_tdata;    // [31:0] power_result

	bit [DATA_W-1:0] modulus_now;
	idle_mode_t      idle_mode;
	power_item_t     pending_powers[$];
	power_item_t     head_power;
	int              mismatch_count;

	// directed edge cases: reset modulus of one, wrap modulus, extremes, primes
	stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{32'd1, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001},
		'{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		'{32'd1, 32'h0000_0005, 32'h0000_0000, 1'b1, 32'h0000_0001},
		'{32'd1, 32'h0000_0007, 32'h0000_0003, 1'b1, 32'h0000_0000},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0002, 1'b1, 32'h0000_0001},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE},
		'{32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0020, 1'b1, 32'h0000_0001},
		'{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001},
		'{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0005, 1'b1, 32'h0000_0000},
		'{32'h0000_0000, 32'h0000_0002, 32'h0000_001F, 1'b1, 32'h8000_0000},
		'{32'h0000_0000, 32'h0000_0002, 32'h0000_0020, 1'b1, 32'h0000_0000},
		'{32'h0000_0000, 32'h0000_0003, 32'h0000_0000, 1'b1, 32'h0000_0001},
		'{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0002, 1'b1, 32'h0000_0001},
		'{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
		'{32'd2, 32'h0000_0003, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
		'{32'd2, 32'h0000_0004, 32'h0000_0001, 1'b1, 32'h0000_0000},
		'{32'd13, 32'h0000_0002, 32'h0000_000C, 1'b1, 32'h0000_0001},
		'{32'd13, 32'h0000_3039, 32'h0000_1A85, 1'b0, 32'h0000_0000},
		'{32'hFFFF_FFFB, 32'h1234_5678, 32'hFFFF_FFFA, 1'b1, 32'h0000_0001},
		'{32'hFFFF_FFFB, 32'h89AB_CDEF, 32'h8000_0001, 1'b0, 32'h0000_0000},
		'{32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 1'b0, 32'h0000_0000}
	};

	modular_exponentiation dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// square-and-multiply at double width; a modulus of zero means 2^32
	function automatic bit [DATA_W-1:0] power_mod(input bit [DATA_W-1:0] base,
			input bit [DATA_W-1:0] exponent, input bit [DATA_W-1:0] modulus);
		bit [2*DATA_W-1:0] wide_mod;
		bit [2*DATA_W-1:0] reduced_base;
		bit [2*DATA_W-1:0] acc;
		wide_mod = (modulus == '0) ? (64'd1 << DATA_W) : {{DATA_W{1'b0}}, modulus};
		if (exponent == '0)
			return 1;
		reduced_base = {{DATA_W{1'b0}}, base} % wide_mod;
		acc = 1;
		for (int i = DATA_W - 1; i >= 0; i--) begin
			acc = (acc * acc) % wide_mod;
			if (exponent[i])
				acc = (acc * reduced_base) % wide_mod;
		end
		return acc[DATA_W-1:0];
	endfunction

	function automatic bit sender_gap();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(99) < 52;
			IDLE_BOTH:   return $urandom_range(99) < 21;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stall();
		case (idle_mode)
			IDLE_RECEIVER: return $urandom_range(99) < 52;
			IDLE_BOTH:     return $urandom_range(99) < 21;
			default:       return 1'b0;
		endcase
	endfunction

	// bases lean on the reduction edges around the current modulus
	function automatic bit [DATA_W-1:0] pick_base();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return modulus_now - 1;
			3:       return modulus_now;
			4:       return $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	function automatic bit [DATA_W-1:0] pick_exponent();
		case ($urandom_range(9))
			0:       return '0;
			1:       return 1;
			2:       return '1;
			3:       return $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	// one input beat; the expectation is queued at the accepting edge
	task automatic push_item(input bit [DATA_W-1:0] base, input bit [DATA_W-1:0] exponent,
			input bit known, input bit [DATA_W-1:0] power);
		power_item_t item;
		@(negedge clk);
		while (sender_gap()) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {exponent, base};
		do @(posedge clk); while (!s_axis_tready);
		item.base = base;
		item.exponent = exponent;
		item.power = known ? power : power_mod(base, exponent, modulus_now);
		pending_powers.push_back(item);
	endtask

	// new modulus only once every result is back and the block has settled
	task automatic write_modulus(input bit [DATA_W-1:0] value);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_powers.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		modulus_now = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side stalls
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= arst_n && !receiver_stall();
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_powers.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %h",
					$time, m_axis_tdata);
				mismatch_count++;
			end else begin
				head_power = pending_powers.pop_front();
				if (m_axis_tdata !== head_power.power) begin
					$display("%0t: power_result for base %h exponent %h, expected %h, actual %h",
						$time, head_power.base, head_power.exponent, head_power.power,
						m_axis_tdata);
					mismatch_count++;
				end
			end
		end
	end

	// run limit
	initial begin
		#(50_000_000);
		$display("modular_exponentiation: mismatch");
		$finish;
	end

	// stimulus
	initial begin
		bit [DATA_W-1:0] next_modulus;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		modulus_now = 1;
		idle_mode = IDLE_NONE;
		mismatch_count = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (directed_rows[r].modulus != modulus_now)
				write_modulus(directed_rows[r].modulus);
			push_item(directed_rows[r].base, directed_rows[r].exponent,
				directed_rows[r].known, directed_rows[r].power);
		end

		// random phases, each with its own modulus and idling pattern
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				1:       next_modulus = '1;
				2:       next_modulus = '0;
				3:       next_modulus = 1;
				4:       next_modulus = 2;
				5:       next_modulus = $urandom_range(3, 1000);
				6:       next_modulus = $urandom | 32'h8000_0000;
				7:       next_modulus = 32'hFFFF_FFFB;
				default: next_modulus = $urandom;
			endcase
			if (next_modulus != modulus_now)
				write_modulus(next_modulus);
			idle_mode = idle_mode_t'(phase % 4);
			repeat (PHASE_ITEMS)
				push_item(pick_base(), pick_exponent(), 1'b0, '0);
		end

		// drain and watch for stray beats
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_powers.size() != 0)
			@(posedge clk);
		repeat (ITEM_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("modular_exponentiation: match");
		else
			$display("modular_exponentiation: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
rtl/modexp_pkg.sv
rtl/modular_exponentiation.sv
rtl/modexp_chk.sv
test/tb_top.sv
